FILE: design/yuyv_to_rgb_framebuffer_writer_defines.svh
// Assertion macros shared by the YUYV to RGB framebuffer writer.
`ifndef YUYV_TO_RGB_FRAMEBUFFER_WRITER_DEFINES_SVH
`define YUYV_TO_RGB_FRAMEBUFFER_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YRGB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("yrgb same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define YRGB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("yrgb next-cycle check failed");

`endif

FILE: design/yrgb_pkg.sv
// Shared types and constants of the YUYV to RGB framebuffer writer.
package yrgb_pkg;

   localparam int MAX_FRAME_WIDTH  = 2048;
   localparam int MAX_FRAME_HEIGHT = 2048;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_OFFSET     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_OFFSET     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MODE   = 3'd5;

   localparam logic MODE_RGB565 = 1'b0;
   localparam logic MODE_RGB888 = 1'b1;

   // Division by 10000 is done as a multiply by a rounded-up reciprocal.
   localparam int          RECIP_SHIFT = 37;
   localparam int          CHROMA_PROD_W = 46;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'd9999) / 64'd10000;
   localparam longint unsigned K_G_U  = 64'd3455 * RECIP;
   localparam longint unsigned K_G_V  = 64'd7169 * RECIP;
   localparam longint unsigned K_B_U  = 64'd17790 * RECIP;
   localparam longint unsigned K_R_V  = 64'd4075 * RECIP;
   localparam longint unsigned K_BIAS = 64'd9999 * RECIP;

   typedef struct packed {
      logic signed [9:0] r_add;
      logic signed [9:0] g_sub;
      logic signed [9:0] b_add;
   } yrgb_chroma_type;

endpackage

FILE: design/yrgb_chroma.sv
// Shared chroma terms of one YUYV word, computed once and registered.
module yrgb_chroma
   import yrgb_pkg::*;
(
   input  logic            clock,
   input  logic            load,
   input  logic [7:0]      u_byte,
   input  logic [7:0]      v_byte,
   output yrgb_chroma_type chroma
);

   yrgb_chroma_type chroma_ff;
   yrgb_chroma_type chroma_in;

   logic              u_neg;
   logic              v_neg;
   logic [7:0]        u_abs;
   logic [7:0]        v_abs;
   logic [8:0]        q_gu;
   logic [8:0]        q_gv;
   logic [8:0]        q_bu;
   logic [8:0]        q_rv;
   logic signed [9:0] gu_term;
   logic signed [9:0] gv_term;
   logic signed [9:0] v_signed;
   logic signed [9:0] rv_term;

   function automatic logic [8:0] scale_div(input logic [7:0] mag,
                                            input logic [CHROMA_PROD_W-1:0] k,
                                            input logic [CHROMA_PROD_W-1:0] bias);
      logic [CHROMA_PROD_W-1:0] prod;
      prod = CHROMA_PROD_W'(mag) * k + bias;
      return prod[RECIP_SHIFT +: 9];
   endfunction

   always_comb begin
      u_neg = ~u_byte[7];
      v_neg = ~v_byte[7];
      u_abs = u_byte[7] ? {1'b0, u_byte[6:0]} : 8'(9'd256 - {1'b0, u_byte} - 9'd128);
      v_abs = v_byte[7] ? {1'b0, v_byte[6:0]} : 8'(9'd256 - {1'b0, v_byte} - 9'd128);
      q_gu = scale_div(u_abs, CHROMA_PROD_W'(K_G_U), '0);
      q_gv = scale_div(v_abs, CHROMA_PROD_W'(K_G_V), '0);
      q_bu = scale_div(u_abs, CHROMA_PROD_W'(K_B_U), '0);
      // A negative red term rounds toward minus infinity.
      q_rv = scale_div(v_abs, CHROMA_PROD_W'(K_R_V),
                       v_neg ? CHROMA_PROD_W'(K_BIAS) : '0);
      gu_term  = u_neg ? -$signed({1'b0, q_gu}) : $signed({1'b0, q_gu});
      gv_term  = v_neg ? -$signed({1'b0, q_gv}) : $signed({1'b0, q_gv});
      v_signed = $signed({2'b00, v_byte}) - 10'sd128;
      rv_term  = v_neg ? -$signed({1'b0, q_rv}) : $signed({1'b0, q_rv});
      chroma_in.r_add = v_signed + rv_term;
      chroma_in.g_sub = gu_term + gv_term;
      chroma_in.b_add = u_neg ? -$signed({1'b0, q_bu}) : $signed({1'b0, q_bu});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chroma_ff <= chroma_in;
      end
   end

   assign chroma = chroma_ff;

endmodule

FILE: design/yrgb_lane.sv
// One pixel lane: adds luma to the chroma terms, clamps and packs the color.
module yrgb_lane
   import yrgb_pkg::*;
(
   input  logic [7:0]      luma,
   input  yrgb_chroma_type chroma,
   input  logic            pixel_mode,
   output logic [23:0]     pixel
);

   logic signed [10:0] r_sum;
   logic signed [10:0] g_sum;
   logic signed [10:0] b_sum;
   logic [7:0]         r_val;
   logic [7:0]         g_val;
   logic [7:0]         b_val;

   function automatic logic [7:0] clamp8(input logic signed [10:0] x);
      if (x < 0) begin
         return 8'd0;
      end else if (x > 11'sd255) begin
         return 8'd255;
      end
      return x[7:0];
   endfunction

   always_comb begin
      r_sum = $signed({3'b000, luma}) + 11'(chroma.r_add);
      g_sum = $signed({3'b000, luma}) - 11'(chroma.g_sub);
      b_sum = $signed({3'b000, luma}) + 11'(chroma.b_add);
      r_val = clamp8(r_sum);
      g_val = clamp8(g_sum);
      b_val = clamp8(b_sum);
      case (pixel_mode)
         MODE_RGB888: begin
            pixel = {r_val, g_val, b_val};
         end
         default: begin
            pixel = {8'd0, r_val[7:3], g_val[7:2], b_val[7:3]};
         end
      endcase
   end

endmodule

FILE: design/yuyv_to_rgb_framebuffer_writer.sv
// Top level: YUYV 4:2:2 word to two RGB pixels with their framebuffer address.
// An accepted item passes through the stage-one registers and then the rsp_ output registers.
// Throughput: one item per cycle while rsp_stall is not held, set by the two pipeline registers.
// The address multiply sits in the first stage, the two pixel lanes in the second.
// Synchronous reset loads the CSR defaults and clears the pipeline valids and position counters.
`include "yuyv_to_rgb_framebuffer_writer_defines.svh"
module yuyv_to_rgb_framebuffer_writer
   import yrgb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_first_of_frame,
   input  logic [31:0]            req_yuyv_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [26:0]            rsp_byte_address,
   output logic [23:0]            rsp_pixel_left,
   output logic [23:0]            rsp_pixel_right,
   output logic                   rsp_last_of_frame,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [11:0] frame_width_ff;
   logic [11:0] frame_height_ff;
   logic [11:0] x_offset_ff;
   logic [11:0] y_offset_ff;
   logic [12:0] screen_width_ff;
   logic        pixel_mode_ff;

   logic [9:0]  pair_column_ff;
   logic [9:0]  pair_column_in;
   logic [10:0] row_index_ff;
   logic [10:0] row_index_in;

   logic        s1_valid_ff;
   logic [25:0] s1_prod_ff;
   logic [25:0] s1_prod_in;
   logic [12:0] s1_col_ff;
   logic [12:0] s1_col_in;
   logic [7:0]  s1_y0_ff;
   logic [7:0]  s1_y1_ff;
   logic        s1_last_ff;

   logic        rsp_valid_ff;
   logic [26:0] rsp_addr_ff;
   logic [26:0] rsp_addr_in;
   logic [23:0] rsp_left_ff;
   logic [23:0] rsp_left_in;
   logic [23:0] rsp_right_ff;
   logic [23:0] rsp_right_in;
   logic        rsp_last_ff;

   logic        adv2;
   logic        adv1;
   logic        accept;
   logic [11:0] width_lim;
   logic [10:0] pairs_eff;
   logic [11:0] height_eff;
   logic [9:0]  cur_pair;
   logic [10:0] cur_row;
   logic        line_end;
   logic        row_end;
   logic        last_in;
   logic [12:0] row_sum;
   logic [26:0] addr_sum;

   yrgb_chroma_type chroma;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 12'd176;
         frame_height_ff <= 12'd144;
         x_offset_ff     <= 12'd0;
         y_offset_ff     <= 12'd0;
         screen_width_ff <= 13'd640;
         pixel_mode_ff   <= MODE_RGB565;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[11:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[11:0];
            CSR_X_OFFSET:     x_offset_ff     <= csr_data[11:0];
            CSR_Y_OFFSET:     y_offset_ff     <= csr_data[11:0];
            CSR_SCREEN_WIDTH: screen_width_ff <= csr_data;
            CSR_PIXEL_MODE:   pixel_mode_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign adv2      = ~rsp_valid_ff | ~rsp_stall;
   assign adv1      = ~s1_valid_ff | adv2;
   assign accept    = req_valid & adv1;
   assign req_stall = ~adv1;

   always_comb begin
      width_lim  = (frame_width_ff > 12'(MAX_FRAME_WIDTH)) ? 12'(MAX_FRAME_WIDTH)
                                                           : frame_width_ff;
      pairs_eff  = (width_lim[11:1] == 11'd0) ? 11'd1 : width_lim[11:1];
      height_eff = (frame_height_ff > 12'(MAX_FRAME_HEIGHT)) ? 12'(MAX_FRAME_HEIGHT)
                                                             : frame_height_ff;
      if (height_eff == 12'd0) begin
         height_eff = 12'd1;
      end
      cur_pair = req_first_of_frame ? 10'd0 : pair_column_ff;
      cur_row  = req_first_of_frame ? 11'd0 : row_index_ff;
      line_end = ({1'b0, cur_pair} + 11'd1) >= pairs_eff;
      row_end  = ({1'b0, cur_row} + 12'd1) >= height_eff;
      last_in  = line_end & row_end;
      if (line_end) begin
         pair_column_in = 10'd0;
         row_index_in   = row_end ? 11'd0 : 11'(cur_row + 11'd1);
      end else begin
         pair_column_in = 10'(cur_pair + 10'd1);
         row_index_in   = cur_row;
      end
      row_sum    = 13'(cur_row) + 13'(y_offset_ff);
      s1_prod_in = 26'(row_sum) * 26'(screen_width_ff);
      s1_col_in  = 13'({cur_pair, 1'b0}) + 13'(x_offset_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_column_ff <= '0;
         row_index_ff   <= '0;
      end else if (accept) begin
         pair_column_ff <= pair_column_in;
         row_index_ff   <= row_index_in;
      end
   end

   yrgb_chroma u_chroma (
      .clock  (clock),
      .load   (accept),
      .u_byte (req_yuyv_word[15:8]),
      .v_byte (req_yuyv_word[31:24]),
      .chroma (chroma)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff <= s1_prod_in;
         s1_col_ff  <= s1_col_in;
         s1_y0_ff   <= req_yuyv_word[7:0];
         s1_y1_ff   <= req_yuyv_word[23:16];
         s1_last_ff <= last_in;
      end
   end

   yrgb_lane u_lane_left (
      .luma       (s1_y0_ff),
      .chroma     (chroma),
      .pixel_mode (pixel_mode_ff),
      .pixel      (rsp_left_in)
   );

   yrgb_lane u_lane_right (
      .luma       (s1_y1_ff),
      .chroma     (chroma),
      .pixel_mode (pixel_mode_ff),
      .pixel      (rsp_right_in)
   );

   always_comb begin
      addr_sum = 27'(s1_prod_ff) + 27'(s1_col_ff);
      case (pixel_mode_ff)
         MODE_RGB888: rsp_addr_in = {addr_sum[24:0], 2'b00};
         default:     rsp_addr_in = {addr_sum[25:0], 1'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_address  = rsp_addr_ff;
   assign rsp_pixel_left    = rsp_left_ff;
   assign rsp_pixel_right   = rsp_right_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   `YRGB_ASSERT_SAME(a_stall_only_when_full, req_stall, s1_valid_ff && !adv2)
   `YRGB_ASSERT_NEXT(a_accept_fills_stage1, accept, s1_valid_ff)
   `YRGB_ASSERT_NEXT(a_stage1_moves_on, s1_valid_ff && adv2, rsp_valid_ff)
   `YRGB_ASSERT_NEXT(a_frame_end_rewinds, accept && last_in,
                     pair_column_ff == 10'd0 && row_index_ff == 11'd0)

endmodule

FILE: sim/yuyv_to_rgb_framebuffer_writer_test.sv
// Self-checking testbench of the YUYV to RGB framebuffer writer with its own pixel predictor.
`timescale 1ns / 100ps
module yuyv_to_rgb_framebuffer_writer_test
   import yrgb_pkg::*;
();

   typedef struct packed {
      logic [26:0] byte_address;
      logic [23:0] pixel_left;
      logic [23:0] pixel_right;
      logic        last_of_frame;
   } pixel_pair_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_first_of_frame;
   logic [31:0]            req_yuyv_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [26:0]            rsp_byte_address;
   logic [23:0]            rsp_pixel_left;
   logic [23:0]            rsp_pixel_right;
   logic                   rsp_last_of_frame;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   pixel_pair_type expected_pairs[$];
   int unsigned fb_width, fb_height, fb_x_off, fb_y_off, fb_pitch;
   logic        fb_mode;
   int unsigned pair_col, row_idx;
   int          fail_count = 0;
   bit          no_idle = 1'b0;

   yuyv_to_rgb_framebuffer_writer u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clamp_byte(int x);
      if (x < 0) return 0;
      if (x > 255) return 255;
      return x;
   endfunction

   function automatic logic [23:0] pack_pixel(int luma, int cb, int cr);
      int r_num, r, g, b;
      logic [7:0] r8, g8, b8;
      r_num = 10000 * luma + 14075 * cr;
      r = r_num / 10000;
      if (r_num % 10000 != 0 && r_num < 0) r = r - 1;
      r = clamp_byte(r);
      g = clamp_byte(luma - (3455 * cb) / 10000 - (7169 * cr) / 10000);
      b = clamp_byte(luma + (17790 * cb) / 10000);
      r8 = r[7:0];
      g8 = g[7:0];
      b8 = b[7:0];
      if (fb_mode == MODE_RGB888) return {r8, g8, b8};
      return {8'h00, r8[7:3], g8[7:2], b8[7:3]};
   endfunction

   // Computes the result of one item and advances the pair and row position.
   function automatic pixel_pair_type next_pixel_pair(logic first, logic [31:0] word);
      int unsigned w, h, pairs, bytes;
      longint unsigned addr;
      logic line_end;
      int cb, cr;
      pixel_pair_type p;
      w = (fb_width > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : fb_width;
      h = (fb_height > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : fb_height;
      pairs = w / 2;
      if (pairs == 0) pairs = 1;
      if (h == 0) h = 1;
      if (first) begin
         pair_col = 0;
         row_idx = 0;
      end
      bytes = (fb_mode == MODE_RGB888) ? 4 : 2;
      addr = 64'(row_idx) + 64'(fb_y_off);
      addr = addr * 64'(fb_pitch) + 64'(2 * pair_col) + 64'(fb_x_off);
      addr = addr * 64'(bytes);
      line_end = (pair_col + 1 >= pairs);
      cb = int'(word[15:8]) - 128;
      cr = int'(word[31:24]) - 128;
      p.byte_address = addr[26:0];
      p.pixel_left = pack_pixel(int'(word[7:0]), cb, cr);
      p.pixel_right = pack_pixel(int'(word[23:16]), cb, cr);
      p.last_of_frame = line_end && (row_idx + 1 >= h);
      if (line_end) begin
         pair_col = 0;
         row_idx = (row_idx + 1 >= h) ? 0 : row_idx + 1;
      end else begin
         pair_col = pair_col + 1;
      end
      return p;
   endfunction

   function automatic logic [31:0] random_yuyv();
      logic [31:0] word;
      word = $urandom;
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: word[8*i +: 8] = 8'h00;
               1: word[8*i +: 8] = 8'hff;
               default: word[8*i +: 8] = 8'h80;
            endcase
         end
      end
      return word;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      logic [CSR_DATA_W-1:0] data;
      data = value[CSR_DATA_W-1:0];
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_FRAME_WIDTH: fb_width = 32'(data[11:0]);
         CSR_FRAME_HEIGHT: fb_height = 32'(data[11:0]);
         CSR_X_OFFSET: fb_x_off = 32'(data[11:0]);
         CSR_Y_OFFSET: fb_y_off = 32'(data[11:0]);
         CSR_SCREEN_WIDTH: fb_pitch = 32'(data);
         CSR_PIXEL_MODE: fb_mode = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure_frame(input int unsigned width, input int unsigned height,
                                  input int unsigned x_pos, input int unsigned y_pos,
                                  input int unsigned pitch, input logic mode);
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_FRAME_HEIGHT, height);
      write_register(CSR_X_OFFSET, x_pos);
      write_register(CSR_Y_OFFSET, y_pos);
      write_register(CSR_SCREEN_WIDTH, pitch);
      write_register(CSR_PIXEL_MODE, 32'(mode));
   endtask

   task automatic send_pair(input logic first, input logic [31:0] word);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_of_frame <= first;
      req_yuyv_word <= word;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_pairs.push_back(next_pixel_pair(first, word));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed frames, with a stray frame start now and then.
   task automatic send_random_pairs(input int count);
      logic first;
      repeat (count) begin
         if (pair_col == 0 && row_idx == 0) first = ($urandom_range(0, 9) != 0);
         else first = ($urandom_range(0, 29) == 0);
         send_pair(first, random_yuyv());
         if (!no_idle && $urandom_range(0, 149) == 0) wait_for_results();
      end
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   task automatic test_color_extremes();
      logic [31:0] words [6] = '{32'h00000000, 32'hffffffff, 32'h80ff8000,
                                 32'hff00ff00, 32'h00ff00ff, 32'h7f807f80};
      foreach (words[i]) send_pair(1'b0, words[i]);
      wait_for_results();
      write_register(CSR_PIXEL_MODE, 32'(MODE_RGB888));
      foreach (words[i]) send_pair(1'b0, words[i]);
   endtask

   task automatic test_frame_shapes();
      wait_for_results();
      configure_frame(4, 2, 3, 5, 0, MODE_RGB565);
      send_pair(1'b1, random_yuyv());
      repeat (4) send_pair(1'b0, random_yuyv());
      send_pair(1'b1, random_yuyv());
      wait_for_results();
      configure_frame(5, 0, 0, 1, 7, MODE_RGB888);
      send_pair(1'b1, random_yuyv());
      repeat (2) send_pair(1'b0, random_yuyv());
      wait_for_results();
      configure_frame(1, 1, 9, 0, 33, MODE_RGB565);
      repeat (2) send_pair(1'b0, random_yuyv());
   endtask

   task automatic test_address_wrap();
      wait_for_results();
      configure_frame(4, 2, 4095, 4095, 8191, MODE_RGB888);
      send_pair(1'b1, random_yuyv());
      repeat (3) send_pair(1'b0, random_yuyv());
   endtask

   task automatic test_shrink_mid_frame();
      wait_for_results();
      configure_frame(12, 4, 1, 2, 100, MODE_RGB565);
      send_pair(1'b1, random_yuyv());
      repeat (7) send_pair(1'b0, random_yuyv());
      wait_for_results();
      write_register(CSR_FRAME_WIDTH, 2);
      write_register(CSR_FRAME_HEIGHT, 1);
      repeat (2) send_pair(1'b0, random_yuyv());
   endtask

   task automatic test_size_limits();
      wait_for_results();
      configure_frame(4095, 1, 0, 0, 640, MODE_RGB888);
      send_pair(1'b1, random_yuyv());
      repeat (40) send_pair(1'b0, random_yuyv());
      wait_for_results();
      configure_frame(0, 4095, 7, 9, 3, MODE_RGB565);
      send_pair(1'b1, random_yuyv());
      repeat (40) send_pair(1'b0, random_yuyv());
   endtask

   task automatic test_random_frames();
      repeat (4) begin
         wait_for_results();
         configure_frame(($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(0, 16),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(0, 4),
                         $urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 8191), 1'($urandom_range(0, 1)));
         send_random_pairs($urandom_range(70, 110));
      end
   endtask

   task automatic test_steady_stream();
      no_idle = 1'b1;
      send_random_pairs(60);
   endtask

   initial begin : receiver_stalls
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : result_checker
      pixel_pair_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_pairs.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected item, expected none, actual address %h",
                        $time, rsp_byte_address);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_byte_address !== want.byte_address)
                  note_mismatch("byte_address", 32'(want.byte_address),
                                32'(rsp_byte_address));
               if (rsp_pixel_left !== want.pixel_left)
                  note_mismatch("pixel_left", 32'(want.pixel_left), 32'(rsp_pixel_left));
               if (rsp_pixel_right !== want.pixel_right)
                  note_mismatch("pixel_right", 32'(want.pixel_right),
                                32'(rsp_pixel_right));
               if (rsp_last_of_frame !== want.last_of_frame)
                  note_mismatch("last_of_frame", 32'(want.last_of_frame),
                                32'(rsp_last_of_frame));
            end
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      fb_width = 176;
      fb_height = 144;
      fb_x_off = 0;
      fb_y_off = 0;
      fb_pitch = 640;
      fb_mode = MODE_RGB565;
      pair_col = 0;
      row_idx = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_first_of_frame <= 1'b0;
      req_yuyv_word <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_color_extremes();
      test_frame_shapes();
      test_address_wrap();
      test_shrink_mid_frame();
      test_size_limits();
      test_random_frames();
      test_steady_stream();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
